### rtl/gda_pkg.sv
// Shared widths, month constants and the month length table for the date adder.
package gda_pkg;

   // Field widths of the request and response beats.
   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 14;
   localparam int ADD_W   = 15;

   // Internal widths: the running day count, the year counter one bit wider than the
   // year field, and the quotient of the start year divided by 25.
   localparam int REM_W      = 16;
   localparam int YEAR_CNT_W = 15;
   localparam int QUO_W      = 10;

   // Month numbers that the sequencer tests by name.
   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
   localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
   localparam logic [MONTH_W-1:0] MONTH_MAY = 4'd5;
   localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
   localparam logic [MONTH_W-1:0] MONTH_JUL = 4'd7;
   localparam logic [MONTH_W-1:0] MONTH_AUG = 4'd8;
   localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
   localparam logic [MONTH_W-1:0] MONTH_OCT = 4'd10;
   localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   // Length of a month in days; codes outside January to December have no days.
   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
      logic [DAY_W-1:0] len;
      case (m)
         MONTH_JAN: len = 5'd31;
         MONTH_FEB: len = leap ? 5'd29 : 5'd28;
         MONTH_MAR: len = 5'd31;
         MONTH_APR: len = 5'd30;
         MONTH_MAY: len = 5'd31;
         MONTH_JUN: len = 5'd30;
         MONTH_JUL: len = 5'd31;
         MONTH_AUG: len = 5'd31;
         MONTH_SEP: len = 5'd30;
         MONTH_OCT: len = 5'd31;
         MONTH_NOV: len = 5'd30;
         MONTH_DEC: len = 5'd31;
         default:   len = 5'd0;
      endcase
      return len;
   endfunction

endpackage

### rtl/gda_req_if.sv
// Request channel: start date and day count, with valid/ready handshake.
interface gda_req_if;
   logic                        valid;
   logic                        ready;
   logic [gda_pkg::DAY_W-1:0]   start_day;
   logic [gda_pkg::MONTH_W-1:0] start_month;
   logic [gda_pkg::YEAR_W-1:0]  start_year;
   logic [gda_pkg::ADD_W-1:0]   days_to_add;

   modport source (output valid, output start_day, output start_month,
                   output start_year, output days_to_add, input ready);
   modport sink (input valid, input start_day, input start_month,
                 input start_year, input days_to_add, output ready);
endinterface

### rtl/gda_rsp_if.sv
// Response channel: resulting date, with valid/ready handshake.
interface gda_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [gda_pkg::DAY_W-1:0]   result_day;
   logic [gda_pkg::MONTH_W-1:0] result_month;
   logic [gda_pkg::YEAR_W-1:0]  result_year;

   modport source (output valid, output result_day, output result_month,
                   output result_year, input ready);
   modport sink (input valid, input result_day, input result_month,
                 input result_year, output ready);
endinterface

### rtl/gregorian_date_add_days.sv
// Gregorian date adder: one shared add/subtract unit under a small sequencer.
// Steps: accept, reduce the year mod 25, sum the months before the start, walk, respond.
// The month walk dominates: the shared unit subtracts one month length per cycle.
// A new beat is taken only when the sequencer is idle; a finished result waits in
// the response register, so the next beat is accepted while it is still pending.
// Reset is synchronous, active high, and clears the sequencer and the response valid.
module gregorian_date_add_days (
   input  logic     clock,
   input  logic     reset,
   gda_req_if.sink  req_chan,
   gda_rsp_if.source rsp_chan
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MOD,
      ST_SUM,
      ST_WALK
   } state_type;

   // Year modulo 25: the quotient comes from a reciprocal multiplication at accept
   // time, and the shared unit then takes 25 times the quotient off the year.
   localparam int                         QUO_SHIFT = 20;
   localparam logic [gda_pkg::REM_W-1:0]  RECIP_25  = 16'd41944;
   localparam logic [gda_pkg::YEAR_W-1:0] MOD_LAST  = 14'd24;

   state_type                         state_ff, state_in;
   logic [gda_pkg::REM_W-1:0]         rem_ff, rem_in;
   logic [gda_pkg::YEAR_W-1:0]        red_ff, red_in;
   logic [gda_pkg::QUO_W-1:0]         quo_ff, quo_in;
   logic [gda_pkg::MONTH_W-1:0]       month_ff, month_in;
   logic [gda_pkg::MONTH_W-1:0]       m_ff, m_in;
   logic [gda_pkg::YEAR_CNT_W-1:0]    year_ff, year_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [gda_pkg::DAY_W-1:0]         rsp_day_ff, rsp_day_in;
   logic [gda_pkg::MONTH_W-1:0]       rsp_month_ff, rsp_month_in;
   logic [gda_pkg::YEAR_W-1:0]        rsp_year_ff, rsp_year_in;

   // Shared arithmetic unit operands and result.
   logic [gda_pkg::REM_W-1:0]         op_a;
   logic [gda_pkg::REM_W-1:0]         op_b;
   logic                              op_sub;
   logic [gda_pkg::REM_W:0]           op_res;

   logic [gda_pkg::YEAR_W+gda_pkg::REM_W-1:0] quo_prod;
   logic [gda_pkg::REM_W-1:0]         quo_x25;
   logic                              leap;
   logic [gda_pkg::DAY_W-1:0]         cur_len;
   logic                              req_fire;
   logic                              rsp_load;
   logic                              walk_more;
   logic                              sum_more;

   // Leap year: divisible by 4, and not by 100 unless by 400 (mod 25 plus low bits).
   assign leap = (year_ff[1:0] == 2'd0) && ((red_ff != '0) || (year_ff[3:0] == 4'd0));
   assign cur_len = gda_pkg::month_len(m_ff, leap);

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire = req_chan.valid && req_chan.ready;

   // The scaled reciprocal is exact for every 14-bit year.
   assign quo_prod = {{gda_pkg::REM_W{1'b0}}, req_chan.start_year} *
                     {{gda_pkg::YEAR_W{1'b0}}, RECIP_25};
   assign quo_x25  = {2'b0, quo_ff, 4'b0} + {3'b0, quo_ff, 3'b0} + {6'b0, quo_ff};

   // Operand selection for the shared add/subtract unit.
   always_comb begin
      op_a   = rem_ff;
      op_b   = {{(gda_pkg::REM_W-gda_pkg::DAY_W){1'b0}}, cur_len};
      op_sub = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            op_a = {1'b0, req_chan.days_to_add};
            op_b = {{(gda_pkg::REM_W-gda_pkg::DAY_W){1'b0}}, req_chan.start_day};
         end
         ST_MOD: begin
            op_a   = {{(gda_pkg::REM_W-gda_pkg::YEAR_W){1'b0}}, red_ff};
            op_b   = quo_x25;
            op_sub = 1'b1;
         end
         ST_SUM: begin
            op_sub = 1'b0;
         end
         ST_WALK: begin
            op_sub = 1'b1;
         end
         default: begin
            op_sub = 1'b0;
         end
      endcase
   end

   assign op_res = op_sub ? ({1'b0, op_a} - {1'b0, op_b}) : ({1'b0, op_a} + {1'b0, op_b});

   // The remaining count still exceeds the current month when the difference is positive.
   assign walk_more = !op_res[gda_pkg::REM_W] && (op_res[gda_pkg::REM_W-1:0] != '0);
   assign sum_more  = (m_ff < month_ff) && (m_ff <= gda_pkg::MONTH_DEC);
   assign rsp_load  = (state_ff == ST_WALK) && !walk_more &&
                      (!rsp_valid_ff || rsp_chan.ready);

   // Sequencer next-state logic.
   always_comb begin
      state_in     = state_ff;
      rem_in       = rem_ff;
      red_in       = red_ff;
      quo_in       = quo_ff;
      month_in     = month_ff;
      m_in         = m_ff;
      year_in      = year_ff;
      rsp_day_in   = rsp_day_ff;
      rsp_month_in = rsp_month_ff;
      rsp_year_in  = rsp_year_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rem_in   = op_res[gda_pkg::REM_W-1:0];
               red_in   = req_chan.start_year;
               quo_in   = quo_prod[QUO_SHIFT +: gda_pkg::QUO_W];
               year_in  = {1'b0, req_chan.start_year};
               month_in = req_chan.start_month;
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            // Take 25 times the quotient off the year, leaving the residue.
            red_in   = op_res[gda_pkg::YEAR_W-1:0];
            m_in     = gda_pkg::MONTH_JAN;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            // Add the lengths of the months before the start month.
            if (sum_more) begin
               rem_in = op_res[gda_pkg::REM_W-1:0];
               m_in   = m_ff + 1'b1;
            end else begin
               m_in     = gda_pkg::MONTH_JAN;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            // Take off one whole month, rolling into the next year after December.
            if (walk_more) begin
               rem_in = op_res[gda_pkg::REM_W-1:0];
               if (m_ff == gda_pkg::MONTH_DEC) begin
                  m_in    = gda_pkg::MONTH_JAN;
                  year_in = year_ff + 1'b1;
                  red_in  = (red_ff == MOD_LAST) ? '0 : red_ff + 1'b1;
               end else begin
                  m_in = m_ff + 1'b1;
               end
            end else if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_day_in   = rem_ff[gda_pkg::DAY_W-1:0];
               rsp_month_in = m_ff;
               rsp_year_in  = year_ff[gda_pkg::YEAR_W-1:0];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, working registers and the response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rem_ff       <= rem_in;
      red_ff       <= red_in;
      quo_ff       <= quo_in;
      month_ff     <= month_in;
      m_ff         <= m_in;
      year_ff      <= year_in;
      rsp_day_ff   <= rsp_day_in;
      rsp_month_ff <= rsp_month_in;
      rsp_year_ff  <= rsp_year_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.result_day   = rsp_day_ff;
   assign rsp_chan.result_month = rsp_month_ff;
   assign rsp_chan.result_year  = rsp_year_ff;

`ifndef NO_ASSERTIONS
   // Once the reduction is over, the year residue stays below 25.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUM || state_ff == ST_WALK) |-> (red_ff <= MOD_LAST))
      else $error("year residue out of range");

   // The month walk only visits real months.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (m_ff >= gda_pkg::MONTH_JAN && m_ff <= gda_pkg::MONTH_DEC))
      else $error("walk month out of range");

   // A result leaves the walk only when the remainder fits in a day field.
   assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (rem_ff <= 16'd31))
      else $error("remainder too large for a day");

   // A pending result is not overwritten before it is taken.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |=> (rsp_valid_ff && $stable(rsp_day_ff)))
      else $error("pending result lost");
`endif

endmodule

### test/gda_date_checker.sv
// Channel monitor and scoreboard for the Gregorian date adder.
module gda_date_checker (
   input  logic        clock,
   input  logic        reset,
   gda_req_if          req_mon,
   gda_rsp_if          rsp_mon,
   output int unsigned mismatch_count,
   output int unsigned dates_pending,
   output int unsigned dates_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [gda_pkg::DAY_W-1:0]   day;
      logic [gda_pkg::MONTH_W-1:0] month;
      logic [gda_pkg::YEAR_W-1:0]  year;
   } date_type;

   // Dates that the accepted request beats should produce, oldest first.
   date_type expected_dates[$];

   int unsigned fails   = 0;
   int unsigned pending = 0;
   int unsigned checked = 0;

   assign mismatch_count = fails;
   assign dates_pending  = pending;
   assign dates_checked  = checked;

   // The year counter here is 32 bits wide, so the leap test past the output width is exact.
   function automatic bit is_leap_year(int unsigned yr);
      return ((yr % 4) == 0 && (yr % 100) != 0) || (yr % 400) == 0;
   endfunction

   function automatic int unsigned days_of_month(int unsigned mon, int unsigned yr);
      if (mon < gda_pkg::MONTH_JAN || mon > gda_pkg::MONTH_DEC) return 0;
      if (mon == gda_pkg::MONTH_FEB) return is_leap_year(yr) ? 29 : 28;
      if (mon == gda_pkg::MONTH_APR || mon == gda_pkg::MONTH_JUN ||
          mon == gda_pkg::MONTH_SEP || mon == gda_pkg::MONTH_NOV)
         return 30;
      return 31;
   endfunction

   // Fold the start date into a day count, then walk months forward from January.
   function automatic date_type add_days_to_date(logic [gda_pkg::DAY_W-1:0]   start_day,
                                                 logic [gda_pkg::MONTH_W-1:0] start_month,
                                                 logic [gda_pkg::YEAR_W-1:0]  start_year,
                                                 logic [gda_pkg::ADD_W-1:0]   days_to_add);
      int unsigned remaining;
      int unsigned mon;
      int unsigned yr;
      date_type    result;
      remaining = int'(days_to_add) + int'(start_day);
      yr = start_year;
      for (mon = gda_pkg::MONTH_JAN; mon < start_month && mon <= gda_pkg::MONTH_DEC; mon++)
         remaining += days_of_month(mon, yr);
      mon = gda_pkg::MONTH_JAN;
      while (days_of_month(mon, yr) < remaining) begin
         remaining -= days_of_month(mon, yr);
         mon++;
         if (mon > gda_pkg::MONTH_DEC) begin
            mon = gda_pkg::MONTH_JAN;
            yr++;
         end
      end
      result.day   = remaining[gda_pkg::DAY_W-1:0];
      result.month = mon[gda_pkg::MONTH_W-1:0];
      result.year  = yr[gda_pkg::YEAR_W-1:0];
      return result;
   endfunction

   // Compare each response beat with the oldest prediction, then record new requests.
   always @(posedge clock) begin : watch
      date_type want;
      if (!reset) begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_dates.size() == 0) begin
               fails++;
               $display("%0t: unexpected response beat %0d/%0d/%0d", $time,
                        rsp_mon.result_day, rsp_mon.result_month, rsp_mon.result_year);
            end else begin
               want = expected_dates.pop_front();
               checked++;
               if (rsp_mon.result_day !== want.day) begin
                  fails++;
                  $display("%0t: result_day expected %0d actual %0d", $time,
                           want.day, rsp_mon.result_day);
               end
               if (rsp_mon.result_month !== want.month) begin
                  fails++;
                  $display("%0t: result_month expected %0d actual %0d", $time,
                           want.month, rsp_mon.result_month);
               end
               if (rsp_mon.result_year !== want.year) begin
                  fails++;
                  $display("%0t: result_year expected %0d actual %0d", $time,
                           want.year, rsp_mon.result_year);
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            expected_dates.push_back(add_days_to_date(req_mon.start_day, req_mon.start_month,
                                                      req_mon.start_year, req_mon.days_to_add));
         pending = expected_dates.size();
      end
   end

endmodule

### test/tb_gregorian_date_add_days.sv
// Top-level testbench for the Gregorian date adder: clock, reset, stimulus and verdict.
module tb_gregorian_date_add_days;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RANDOM_DATES    = 480;
   localparam int unsigned MAX_IDLE        = 17;
   localparam int unsigned HOLD_OFF_CYCLES = 3000;
   localparam int unsigned TAIL_CYCLES     = 1300;
   localparam int unsigned CYCLE_LIMIT     = 3_000_000;

   logic        clock;
   logic        reset;
   int unsigned cycle_count = 0;
   bit          no_idle = 1'b0;
   bit          hold_off_request = 1'b0;
   int unsigned mismatch_count;
   int unsigned dates_pending;
   int unsigned dates_checked;

   gda_req_if req_bus ();
   gda_rsp_if rsp_bus ();

   gregorian_date_add_days i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   gda_date_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .mismatch_count (mismatch_count),
      .dates_pending  (dates_pending),
      .dates_checked  (dates_checked)
   );

   // 10 ns clock.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d dates outstanding",
                  cycle_count, dates_pending);
         $display("FAIL gregorian_date_add_days");
         $finish;
      end
   end

   function automatic int unsigned idle_cycles();
      return no_idle ? 0 : $urandom_range(0, MAX_IDLE);
   endfunction

   // Response side: random stalls per beat, plus one long hold-off on request.
   initial begin
      int unsigned stall;
      rsp_bus.ready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_bus.ready = 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end else begin
            stall = idle_cycles();
            if (stall > 0) begin
               rsp_bus.ready = 1'b0;
               repeat (stall) @(negedge clock);
            end
         end
         rsp_bus.ready = 1'b1;
         forever begin
            @(posedge clock);
            if (rsp_bus.valid || hold_off_request) break;
         end
         @(negedge clock);
      end
   end

   // Offer one request beat; entered and left at a falling edge.
   task automatic offer_date(input logic [gda_pkg::DAY_W-1:0]   start_day,
                             input logic [gda_pkg::MONTH_W-1:0] start_month,
                             input logic [gda_pkg::YEAR_W-1:0]  start_year,
                             input logic [gda_pkg::ADD_W-1:0]   days_to_add);
      int unsigned gap;
      gap = idle_cycles();
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid       = 1'b1;
      req_bus.start_day   = start_day;
      req_bus.start_month = start_month;
      req_bus.start_year  = start_year;
      req_bus.days_to_add = days_to_add;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   // Let every predicted date come back before going on.
   task automatic wait_for_drain();
      req_bus.valid = 1'b0;
      while (dates_pending != 0) @(negedge clock);
   endtask

   // Mostly calendar dates with modest counts; some raw field noise and full-range counts.
   task automatic offer_random_date(input bit short_count);
      logic [gda_pkg::DAY_W-1:0]   start_day;
      logic [gda_pkg::MONTH_W-1:0] start_month;
      logic [gda_pkg::YEAR_W-1:0]  start_year;
      logic [gda_pkg::ADD_W-1:0]   days_to_add;
      int unsigned                 pick;
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
         start_month = (gda_pkg::MONTH_W)'($urandom_range(gda_pkg::MONTH_JAN,
                                                          gda_pkg::MONTH_DEC));
         start_day   = (gda_pkg::DAY_W)'($urandom_range(1, $urandom_range(0, 1) ? 28 : 31));
         if ($urandom_range(0, 9) == 0)
            start_year = (gda_pkg::YEAR_W)'(100 * $urandom_range(0, 99));
         else
            start_year = (gda_pkg::YEAR_W)'($urandom_range(0, 9999));
      end else begin
         start_day   = (gda_pkg::DAY_W)'($urandom);
         start_month = (gda_pkg::MONTH_W)'($urandom);
         start_year  = (gda_pkg::YEAR_W)'($urandom);
      end
      pick = $urandom_range(0, 99);
      if (short_count || pick < 70)
         days_to_add = (gda_pkg::ADD_W)'($urandom_range(0, 400));
      else if (pick < 90)
         days_to_add = (gda_pkg::ADD_W)'($urandom_range(0, 5000));
      else
         days_to_add = (gda_pkg::ADD_W)'($urandom);
      offer_date(start_day, start_month, start_year, days_to_add);
   endtask

   // Reset, directed corners, random traffic, drain and verdict.
   initial begin
      int unsigned n;
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.start_day   = '0;
      req_bus.start_month = '0;
      req_bus.start_year  = '0;
      req_bus.days_to_add = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Year boundaries and the three leap rules in February.
      offer_date(5'd1, gda_pkg::MONTH_JAN, 14'd2000, 15'd0);
      offer_date(5'd31, gda_pkg::MONTH_DEC, 14'd1999, 15'd1);
      offer_date(5'd28, gda_pkg::MONTH_FEB, 14'd2000, 15'd1);
      offer_date(5'd28, gda_pkg::MONTH_FEB, 14'd1900, 15'd1);
      offer_date(5'd28, gda_pkg::MONTH_FEB, 14'd2024, 15'd1);
      offer_date(5'd28, gda_pkg::MONTH_FEB, 14'd2023, 15'd1);
      offer_date(5'd28, gda_pkg::MONTH_FEB, 14'd0, 15'd1);
      // Day zero, month zero and months past December.
      offer_date(5'd0, gda_pkg::MONTH_JAN, 14'd1234, 15'd0);
      offer_date(5'd0, 4'd0, 14'd77, 15'd0);
      offer_date(5'd0, gda_pkg::MONTH_MAR, 14'd2000, 15'd0);
      offer_date(5'd15, 4'd0, 14'd2001, 15'd10);
      offer_date(5'd1, 4'd13, 14'd1999, 15'd0);
      offer_date(5'd31, 4'd15, 14'd2399, 15'd5);
      // Start day past the end of its month.
      offer_date(5'd31, gda_pkg::MONTH_FEB, 14'd2100, 15'd0);
      offer_date(5'd31, gda_pkg::MONTH_APR, 14'd2021, 15'd0);
      // Largest counts, and years that run past the output width.
      offer_date(5'd1, gda_pkg::MONTH_JAN, 14'd0, 15'h7FFF);
      offer_date(5'd1, gda_pkg::MONTH_JAN, 14'd9999, 15'h7FFF);
      offer_date(5'd31, gda_pkg::MONTH_DEC, 14'h3FFF, 15'd1);
      offer_date(5'd31, 4'd15, 14'h3FFF, 15'h7FFF);
      offer_date(5'd1, gda_pkg::MONTH_DEC, 14'd2400, 15'd365);
      wait_for_drain();

      for (n = 0; n < RANDOM_DATES; n++) begin
         if (n == 40) begin
            // Keep offering while the response side stalls, so the block backs up.
            wait_for_drain();
            hold_off_request = 1'b1;
            repeat (8) begin
               offer_random_date(1'b1);
               n++;
            end
         end
         if (n % 100 == 99) wait_for_drain();
         no_idle = (n >= 200 && n < 260);
         offer_random_date(1'b0);
      end
      no_idle = 1'b0;
      wait_for_drain();
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("Checked %0d result dates over leap and century Februaries, odd day and month",
               dates_checked);
      $display("codes, year wrap, full-range counts and a long response hold-off.");
      if (mismatch_count == 0) begin
         $display("PASS gregorian_date_add_days");
      end else begin
         $display("FAIL gregorian_date_add_days");
      end
      $finish;
   end

endmodule
